// File: rtl/smt_overlap_time_accumulator_core_defines.svh
// Assertion macros used by the overlap-time accumulator RTL.
// Depends on nothing; included by smt_ota_tracker, the module that carries assertions.
`ifndef SMT_OVERLAP_TIME_ACCUMULATOR_CORE_DEFINES_SVH
`define SMT_OVERLAP_TIME_ACCUMULATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMT_OTA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smt_ota: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMT_OTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smt_ota: next-cycle check failed");

`endif

// File: rtl/smt_ota_pkg.sv
// Types and codes for the overlap-time accumulator.
// Used by every module of the block; depends on nothing.
package smt_ota_pkg;

  localparam int unsigned TimeW = 64;

  typedef enum logic [1:0] {
    FUNC_IDLE_TO_BUSY = 2'd0,
    FUNC_BUSY_TO_IDLE = 2'd1,
    FUNC_BUSY_TO_BUSY = 2'd2,
    FUNC_SAME_TASK    = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic               core;
    logic [TimeW-1:0]   timestamp;
    logic               has_group;
  } item_t;

  typedef struct packed {
    logic               charge_core;
    logic [TimeW-1:0]   overlap_delta;
  } result_t;

endpackage

// File: rtl/smt_overlap_time_accumulator_core.sv
// Overlap-time accumulator for two sibling hardware threads. Each switch event
// is taken into an input register; its state update is applied and its
// result, if it has one, is written to the result register once that
// register can take it, so the block accepts one event per clock while the
// output is not stalled. The update is one 64-bit subtract and compare, then
// one 64-bit add and zero test; the input side stalls only while a result
// beat waits on a stalled output. The user must write the pair_enabled
// register only while no event is in flight; the block does not enforce it.
module smt_overlap_time_accumulator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic        core,
  input  logic [63:0] timestamp,
  input  logic        has_group,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        charge_core,
  output logic [63:0] overlap_delta
);
  import smt_ota_pkg::*;

  item_t    in_item;
  item_t    item;
  result_t  res;
  result_t  out_res;
  logic     fire;
  logic     down_ready;
  logic     res_valid;

  assign in_item.func      = func_t'(func);
  assign in_item.core      = core;
  assign in_item.timestamp = timestamp;
  assign in_item.has_group = has_group;

  smt_ota_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .down_ready (down_ready),
    .fire       (fire),
    .item       (item)
  );

  smt_ota_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  smt_ota_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .ready     (down_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign charge_core   = out_res.charge_core;
  assign overlap_delta = out_res.overlap_delta;

endmodule

// File: rtl/smt_ota_in_stage.sv
// Input register for switch events, with valid/stall handshake.
// Depends on smt_ota_pkg.
module smt_ota_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  smt_ota_pkg::item_t    in_item,
  input  logic                  down_ready,
  output logic                  fire,
  output smt_ota_pkg::item_t    item
);
  import smt_ota_pkg::*;

  logic  valid;
  logic  load;

  // The held beat is consumed whenever the result register can take it.
  assign fire     = valid && down_ready;
  assign in_stall = valid && !down_ready;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || down_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// File: rtl/smt_ota_tracker.sv
// Busy flags, open overlap interval and per-core unreported overlap.
// Depends on smt_ota_pkg and the assertion macro header.
`include "smt_overlap_time_accumulator_core_defines.svh"

module smt_ota_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  fire,
  input  smt_ota_pkg::item_t    item,
  output logic                  res_valid,
  output smt_ota_pkg::result_t  res
);
  import smt_ota_pkg::*;

  logic                 pair_enabled;
  logic [1:0]           busy;
  logic [1:0]           busy_next;
  logic [TimeW-1:0]     start;
  logic [TimeW-1:0]     start_next;
  // Per core: shared total minus what that core last reported, mod 2^64.
  logic [TimeW-1:0]     pending [2];
  logic [TimeW-1:0]     pending_next [2];
  logic [TimeW-1:0]     pend_add [2];
  logic [TimeW-1:0]     diff;
  logic [TimeW-1:0]     add_amt;
  logic                 elapsed_pos;
  logic                 active;
  logic                 closing;

  assign diff        = item.timestamp - start;
  assign elapsed_pos = (start != '0) && (diff != '0) && !diff[TimeW-1];
  assign active      = pair_enabled && (item.func != FUNC_SAME_TASK);
  assign closing     = (item.func == FUNC_BUSY_TO_IDLE) ||
                       (item.func == FUNC_BUSY_TO_BUSY);
  assign add_amt     = elapsed_pos ? diff : '0;
  assign pend_add[0] = pending[0] + add_amt;
  assign pend_add[1] = pending[1] + add_amt;

  assign res_valid         = active && closing && item.has_group &&
                             (pend_add[item.core] != '0);
  assign res.charge_core   = item.core;
  assign res.overlap_delta = pend_add[item.core];

  always_comb begin
    busy_next       = busy;
    start_next      = start;
    pending_next[0] = pending[0];
    pending_next[1] = pending[1];
    if (fire && active) begin
      unique case (item.func)
        FUNC_IDLE_TO_BUSY: begin
          if (busy[~item.core]) begin
            start_next = item.timestamp;
          end
          busy_next[item.core] = 1'b1;
        end
        FUNC_BUSY_TO_IDLE: begin
          pending_next[0]      = pend_add[0];
          pending_next[1]      = pend_add[1];
          start_next           = '0;
          busy_next[item.core] = 1'b0;
        end
        FUNC_BUSY_TO_BUSY: begin
          pending_next[0] = pend_add[0];
          pending_next[1] = pend_add[1];
          if (elapsed_pos) begin
            start_next = item.timestamp;
          end
        end
        default: begin
        end
      endcase
      // A report brings the core level with the shared total.
      if (res_valid) begin
        pending_next[item.core] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_enabled <= 1'b0;
      busy         <= '0;
      start        <= '0;
      pending[0]   <= '0;
      pending[1]   <= '0;
    end else begin
      if (cfg_wr_en) begin
        pair_enabled <= cfg_wr_data;
      end
      busy       <= busy_next;
      start      <= start_next;
      pending[0] <= pending_next[0];
      pending[1] <= pending_next[1];
    end
  end

  `SMT_OTA_ASSERT_SAME(a_res_nonzero, clk, rst, res_valid, res.overlap_delta != '0)
  `SMT_OTA_ASSERT_NEXT(a_report_levels, clk, rst, fire && res_valid, pending[$past(item.core)] == '0)
  `SMT_OTA_ASSERT_NEXT(a_idle_blocks, clk, rst, !pair_enabled && !cfg_wr_en, $stable(busy) && $stable(start))

endmodule

// File: rtl/smt_ota_out_stage.sv
// Result register that holds a beat until the receiver takes it.
// Depends on smt_ota_pkg.
module smt_ota_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  res_valid,
  input  smt_ota_pkg::result_t  res,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output smt_ota_pkg::result_t  out_res
);
  import smt_ota_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && fire && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// File: tb/smt_overlap_time_accumulator_core_tb.sv
// Self-checking testbench for smt_overlap_time_accumulator_core.
// Drives directed and random switch events with random idling on both sides and
// checks each result beat against a fixed or predicted charge; depends on smt_ota_pkg.
`timescale 1ns / 1ps

module smt_overlap_time_accumulator_core_tb;
  import smt_ota_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainPause = 8;
  localparam int unsigned RandomItems = 1300;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        func;
  logic              core;
  logic [TimeW-1:0]  timestamp;
  logic              has_group;
  logic              out_valid;
  logic              out_stall;
  logic              charge_core;
  logic [TimeW-1:0]  overlap_delta;

  smt_overlap_time_accumulator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .core          (core),
    .timestamp     (timestamp),
    .has_group     (has_group),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .charge_core   (charge_core),
    .overlap_delta (overlap_delta)
  );

  // Predictor state, kept in step with the block at each accepted event beat.
  bit               pair_on;
  bit               thread_busy [2];
  logic [TimeW-1:0] open_at;
  logic [TimeW-1:0] shared_total;
  logic [TimeW-1:0] reported [2];

  result_t          pending_charges [$];
  int unsigned      mismatches;
  int unsigned      cycles;
  bit               calm;
  int unsigned      stall_left;
  result_t          want;

  typedef struct {
    bit      cfg_first;
    bit      cfg_val;
    item_t   ev;
    bit      fixed;
    bit      emit;
    result_t res;
  } plan_row_t;

  plan_row_t plan [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL smt_overlap_time_accumulator_core");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Work out the charge caused by one switch event and advance the state.
  function automatic void predict_switch(input item_t ev, output bit emits,
                                         output result_t res);
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] growth;
    bit               added;
    emits = 1'b0;
    res = '0;
    if (!pair_on || ev.func == FUNC_SAME_TASK) return;
    if (ev.func == FUNC_IDLE_TO_BUSY) begin
      if (thread_busy[ev.core ^ 1'b1]) open_at = ev.timestamp;
      thread_busy[ev.core] = 1'b1;
      return;
    end
    // The elapsed time counts only when it is positive as a signed value, and
    // a start time of zero means no interval is open.
    span = ev.timestamp - open_at;
    added = (open_at != '0) && (span != '0) && !span[TimeW-1];
    if (added) shared_total = shared_total + span;
    if (ev.func == FUNC_BUSY_TO_IDLE) begin
      open_at = '0;
      thread_busy[ev.core] = 1'b0;
    end else if (added) begin
      open_at = ev.timestamp;
    end
    if (!ev.has_group) return;
    growth = shared_total - reported[ev.core];
    if (growth == '0) return;
    reported[ev.core] = shared_total;
    emits = 1'b1;
    res.charge_core = ev.core;
    res.overlap_delta = growth;
  endfunction

  function automatic int unsigned pick_len(input bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm && allow_zero) return 0;
    if (allow_zero && r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = pick_len(1'b0) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_charges.size() == 0) begin
        flag_mismatch($sformatf("result beat core %0d delta %0h with nothing pending",
                                charge_core, overlap_delta));
      end else begin
        want = pending_charges.pop_front();
        if (charge_core !== want.charge_core)
          flag_mismatch($sformatf("charge_core %0d, expected %0d",
                                  charge_core, want.charge_core));
        if (overlap_delta !== want.overlap_delta)
          flag_mismatch($sformatf("overlap_delta %0h, expected %0h",
                                  overlap_delta, want.overlap_delta));
      end
    end
  end

  // Sends one event beat; a fixed row replaces the predicted result with its own.
  task automatic send_beat(input item_t ev, input bit fixed, input bit emit,
                           input result_t res);
    int unsigned gap;
    bit          got;
    result_t     guess;
    gap = pick_len(1'b1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= ev.func;
    core      <= ev.core;
    timestamp <= ev.timestamp;
    has_group <= ev.has_group;
    do @(posedge clk); while (in_stall);
    predict_switch(ev, got, guess);
    if (fixed) begin
      got = emit;
      guess = res;
    end
    if (got) pending_charges.push_back(guess);
  endtask

  // Stop sending, wait for every pending charge, then let the pipeline empty.
  task automatic hold_off;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_charges.size() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  task automatic write_pair(input bit val);
    hold_off();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    pair_on = val;
  endtask

  task automatic add_row(input bit cfg_first, input bit cfg_val, input func_t f,
                         input bit c, input logic [TimeW-1:0] ts, input bit g,
                         input bit fixed, input bit emit,
                         input logic [TimeW-1:0] delta);
    plan_row_t row;
    row.cfg_first = cfg_first;
    row.cfg_val = cfg_val;
    row.ev.func = f;
    row.ev.core = c;
    row.ev.timestamp = ts;
    row.ev.has_group = g;
    row.fixed = fixed;
    row.emit = emit;
    row.res.charge_core = c;
    row.res.overlap_delta = delta;
    plan.push_back(row);
  endtask

  initial begin
    item_t            ev;
    logic [TimeW-1:0] tick;
    int unsigned      counted;
    int unsigned      target;
    int unsigned      r;
    bit               val;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    func = FUNC_IDLE_TO_BUSY;
    core = 1'b0;
    timestamp = '0;
    has_group = 1'b0;
    out_stall = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    cycles = 0;
    mismatches = 0;
    pair_on = 1'b0;
    thread_busy[0] = 1'b0;
    thread_busy[1] = 1'b0;
    open_at = '0;
    shared_total = '0;
    reported[0] = '0;
    reported[1] = '0;

    // With the pair disabled every event is dropped.
    add_row(1, 0, FUNC_IDLE_TO_BUSY, 0, 64'd10, 0, 1, 0, 64'd0);
    add_row(0, 0, FUNC_IDLE_TO_BUSY, 1, 64'd20, 0, 1, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 0, 64'd100, 1, 1, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_IDLE, 1, 64'd200, 1, 1, 0, 64'd0);
    add_row(1, 1, FUNC_IDLE_TO_BUSY, 0, 64'd100, 1, 1, 0, 64'd0);
    add_row(0, 0, FUNC_IDLE_TO_BUSY, 1, 64'd150, 0, 1, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 0, 64'd400, 1, 1, 1, 64'd250);
    add_row(0, 0, FUNC_SAME_TASK,    1, 64'd500, 1, 1, 0, 64'd0);
    // Negative elapsed time adds nothing, but the sibling still gets its share.
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 1, 64'd300, 1, 1, 1, 64'd250);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 1, 64'd400, 1, 1, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_IDLE, 0, 64'd1000, 0, 1, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_IDLE, 1, 64'd2000, 1, 1, 1, 64'd600);
    // An interval opened at time zero is treated as closed.
    add_row(0, 0, FUNC_IDLE_TO_BUSY, 0, 64'd0, 0, 0, 0, 64'd0);
    add_row(0, 0, FUNC_IDLE_TO_BUSY, 1, 64'd0, 1, 0, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 0, 64'd5000, 1, 0, 0, 64'd0);
    // Differences at the sign boundary and wrap of the shared total.
    add_row(0, 0, FUNC_IDLE_TO_BUSY, 0, 64'h8000_0000_0000_0000, 0, 0, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 1, 64'd0, 1, 0, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_BUSY, 0, 64'h7FFF_FFFF_FFFF_FFFE, 1, 0, 0, 64'd0);
    add_row(0, 0, FUNC_BUSY_TO_IDLE, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 64'd0);
    add_row(0, 0, FUNC_SAME_TASK,    0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 64'd0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg_first) write_pair(plan[i].cfg_val);
      send_beat(plan[i].ev, plan[i].fixed, plan[i].emit, plan[i].res);
    end

    tick = 64'd1;
    for (int p = 0; p < 8; p++) begin
      val = !(p == 1 || p == 4);
      write_pair(val);
      calm = (p == 3);
      target = val ? RandomItems / 6 : 25;
      counted = 0;
      r = $urandom_range(0, 3);
      if (r == 0) tick = {$urandom, $urandom};
      else if (r == 1) tick = 64'hFFFF_FFFF_FFFF_F000;
      while (counted < target) begin
        // Mostly well-formed sequences on a moving clock, with some noise.
        r = $urandom_range(0, 99);
        if (r < 80) tick = tick + 64'($urandom_range(1, 2000));
        else if (r < 88) tick = tick - 64'($urandom_range(0, 500));
        else if (r < 93) tick = {$urandom, $urandom};
        else if (r < 96) tick = '0;
        else tick = tick + 64'h7FFF_FFFF_FFFF_F000 + 64'($urandom_range(0, 8192));
        ev.core = 1'($urandom_range(0, 1));
        ev.timestamp = tick;
        ev.has_group = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 10) ev.func = func_t'($urandom_range(0, 3));
        else if (!thread_busy[ev.core]) ev.func = FUNC_IDLE_TO_BUSY;
        else if (r < 16) ev.func = FUNC_SAME_TASK;
        else if (r < 50) ev.func = FUNC_BUSY_TO_IDLE;
        else ev.func = FUNC_BUSY_TO_BUSY;
        if (!pair_on || ev.func != FUNC_SAME_TASK) counted++;
        send_beat(ev, 1'b0, 1'b0, '0);
        if (p == 2 && counted == target / 2) hold_off();
      end
    end

    calm = 1'b0;
    hold_off();
    if (mismatches == 0) begin
      $display("PASS smt_overlap_time_accumulator_core");
    end else begin
      $display("FAIL smt_overlap_time_accumulator_core");
    end
    $finish;
  end

endmodule

// File: smt_overlap_time_accumulator_core.f
+incdir+rtl
rtl/smt_ota_pkg.sv
rtl/smt_ota_in_stage.sv
rtl/smt_ota_tracker.sv
rtl/smt_ota_out_stage.sv
rtl/smt_overlap_time_accumulator_core.sv
tb/smt_overlap_time_accumulator_core_tb.sv
